>>> rtl/core/register_vm_execute_unit_assert.svh
// assertion macros for the register vm execute unit checker
// each macro expands to one labeled concurrent assertion on clk, disabled in rst
`ifndef REGISTER_VM_EXECUTE_UNIT_ASSERT_SVH
`define REGISTER_VM_EXECUTE_UNIT_ASSERT_SVH

// property that must hold in the same cycle
`define RVX_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// property that must hold in the next cycle
`define RVX_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/rvx_pkg.sv
// shared types and codes of the register vm execute unit
// no dependencies; used by register_vm_execute_unit and rvx_exec, not by rvx_regfile
`default_nettype none

package rvx_pkg;

  typedef enum logic [3:0] {
    CMD_MOV   = 4'd0,
    CMD_ADD   = 4'd1,
    CMD_SUB   = 4'd2,
    CMD_MUL   = 4'd3,
    CMD_CMP   = 4'd4,
    CMD_JMP   = 4'd5,
    CMD_PRINT = 4'd6,
    CMD_HALT  = 4'd7
  } cmd_t;

  typedef enum logic [2:0] {
    TRAP_OK     = 3'd0,
    TRAP_REG    = 3'd1,
    TRAP_OPND   = 3'd2,
    TRAP_INSN   = 3'd3,
    TRAP_COND   = 3'd4,
    TRAP_CCOUNT = 3'd5,
    TRAP_HALT   = 3'd6,
    TRAP_PC     = 3'd7
  } trap_t;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_REG  = 2'd1;
  localparam logic [1:0] KIND_IMM  = 2'd2;

  localparam logic [2:0] COND_EQ  = 3'd0;
  localparam logic [2:0] COND_GT  = 3'd1;
  localparam logic [2:0] COND_GTE = 3'd2;
  localparam logic [2:0] COND_LT  = 3'd3;
  localparam logic [2:0] COND_LTE = 3'd4;
  localparam logic [2:0] COND_NE  = 3'd5;

  localparam logic [31:0] JUMP_WHEN = 32'd1;

  // first member sits in the highest bits, so cmd lands at bit 0
  typedef struct packed {
    logic               extra_conditions;
    logic [2:0]         condition;
    logic signed [31:0] dest_index;
    logic               has_dest;
    logic signed [31:0] second_value;
    logic [1:0]         second_kind;
    logic signed [31:0] first_value;
    logic [1:0]         first_kind;
    logic [3:0]         cmd;
  } insn_t;

  typedef struct packed {
    logic signed [63:0] print_value;
    logic               print_valid;
    logic signed [63:0] written_value;
    logic [5:0]         written_index;
    logic               reg_written;
    logic [15:0]        next_pc;
    trap_t              trap_code;
  } result_t;

  localparam int INSN_W   = $bits(insn_t);
  localparam int RESULT_W = $bits(result_t);
  localparam int IN_DATA_W  = ((INSN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

>>> rtl/core/register_vm_execute_unit.sv
// Register vm execute unit. Accepts decoded instructions on the s_ side and returns one
// result per executed instruction on the m_ side. The accepting edge captures the
// instruction and reads both source registers into the read-data register (a write at that
// same edge is forwarded); a later edge, once the result register has room, runs the
// single-pass execute (operand select, one 32-bit multiply or add, compare, trap priority)
// and loads the result register while writing the register file. Sustained rate is one
// instruction per clock while m_tready is high, set by that one execute pass that reads the
// previous instruction's write. Any trap, including halt and pc out, sets the stopped flag;
// every later request is taken and dropped without a result until rst. program_length must
// be written through cfg_we/cfg_wdata only while no request is in flight; not enforced here.
// depends on rvx_pkg, rvx_regfile and rvx_exec
`default_nettype none

module register_vm_execute_unit #(
  parameter int REG_COUNT = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // config: program_length
  input  wire logic                           cfg_we,
  input  wire logic [15:0]                    cfg_wdata,
  // request: cmd, first_kind, first_value, second_kind, second_value, has_dest,
  //          dest_index, condition, extra_conditions, zero pad
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [rvx_pkg::IN_DATA_W-1:0]  s_tdata,
  // result: trap_code, next_pc, reg_written, written_index, written_value,
  //         print_valid, print_value, zero pad
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [rvx_pkg::OUT_DATA_W-1:0]      m_tdata
);
  import rvx_pkg::*;

  localparam int IW = $clog2(REG_COUNT);

  insn_t       in_insn;
  insn_t       s1_insn;
  logic        s1_valid;
  logic        s1_fire;
  logic        live;
  logic        accept;
  logic [63:0] reg_a, reg_b;
  logic [15:0] pc;
  logic [15:0] program_length;
  logic        stopped;
  result_t     ex_res;
  result_t     out_res;
  logic        out_valid;
  logic        rf_we;

  assign in_insn = insn_t'(s_tdata[INSN_W-1:0]);

  // execute stage moves when its result has room, or when it is dropped after a stop
  assign s1_fire  = s1_valid && (stopped || !out_valid || m_tready);
  assign live     = s1_fire && !stopped;
  assign s_tready = !s1_valid || s1_fire;
  assign accept   = s_tvalid && s_tready;

  // traps never write
  assign rf_we = live && ex_res.reg_written;

  rvx_regfile #(
    .REG_COUNT (REG_COUNT),
    .IW        (IW)
  ) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .we      (rf_we),
    .waddr   (ex_res.written_index[IW-1:0]),
    .wdata   (ex_res.written_value),
    .re      (accept),
    .raddr_a (in_insn.first_value[IW-1:0]),
    .raddr_b (in_insn.second_value[IW-1:0]),
    .rdata_a (reg_a),
    .rdata_b (reg_b)
  );

  rvx_exec #(
    .REG_COUNT (REG_COUNT)
  ) u_exec (
    .insn           (s1_insn),
    .reg_a          (reg_a),
    .reg_b          (reg_b),
    .pc             (pc),
    .program_length (program_length),
    .res            (ex_res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      pc             <= 16'd0;
      stopped        <= 1'b0;
      program_length <= 16'd0;
    end else begin
      if (cfg_we) begin
        program_length <= cfg_wdata;
      end
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (live) begin
        pc <= ex_res.next_pc;
        if (ex_res.trap_code != TRAP_OK) begin
          stopped <= 1'b1;
        end
      end
      // result register: load on execute, clear when taken
      if (live) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_insn <= in_insn;
    end
    if (live) begin
      out_res <= ex_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_res};

endmodule

`default_nettype wire

>>> rtl/core/rvx_regfile.sv
// register file: flop array with two registered read ports and write-through bypass
// no package dependency; valid bits make unwritten entries read zero
`default_nettype none

module rvx_regfile #(
  parameter int REG_COUNT = 32,
  parameter int IW        = $clog2(REG_COUNT)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic [IW-1:0] waddr,
  input  wire logic [63:0]   wdata,
  input  wire logic          re,
  input  wire logic [IW-1:0] raddr_a,
  input  wire logic [IW-1:0] raddr_b,
  output logic      [63:0]   rdata_a,
  output logic      [63:0]   rdata_b
);
  localparam int DEPTH = 1 << IW;

  logic [63:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data follows a write at the same edge
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && waddr == raddr_a) begin
        rdata_a <= wdata;
      end else begin
        rdata_a <= valid[raddr_a] ? mem[raddr_a] : 64'd0;
      end
      if (we && waddr == raddr_b) begin
        rdata_b <= wdata;
      end else begin
        rdata_b <= valid[raddr_b] ? mem[raddr_b] : 64'd0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rvx_exec.sv
// single-pass instruction execute: operand select, 32-bit alu, compare, trap priority
// depends on rvx_pkg for instruction, result and code types
`default_nettype none

module rvx_exec #(
  parameter int REG_COUNT = 32
) (
  input  wire rvx_pkg::insn_t insn,
  input  wire logic [63:0] reg_a,
  input  wire logic [63:0] reg_b,
  input  wire logic [15:0] pc,
  input  wire logic [15:0] program_length,
  output rvx_pkg::result_t res
);
  import rvx_pkg::*;

  logic [31:0] x1, x2, dst;
  logic        x1_ok, x2_ok, dst_ok;
  logic        a_bad, b_bad, fetch_bad;
  logic [31:0] a, b, alu_r, prod;
  logic        cmp_r, cond_bad;
  trap_t       trap;
  logic        wr, pv;
  logic [5:0]  widx;
  logic [63:0] wval;
  logic [15:0] npc;

  assign x1  = $unsigned(insn.first_value);
  assign x2  = $unsigned(insn.second_value);
  assign dst = $unsigned(insn.dest_index);

  assign x1_ok  = x1 < 32'(REG_COUNT);
  assign x2_ok  = x2 < 32'(REG_COUNT);
  assign dst_ok = dst < 32'(REG_COUNT);

  // operand fetch: none gives zero, register gives its low word
  assign a_bad = (insn.first_kind == KIND_REG) && !x1_ok;
  assign b_bad = (insn.second_kind == KIND_REG) && !x2_ok;
  assign fetch_bad = a_bad || b_bad;
  assign a = (insn.first_kind == KIND_REG) ? reg_a[31:0] :
             (insn.first_kind == KIND_IMM) ? x1 : 32'd0;
  assign b = (insn.second_kind == KIND_REG) ? reg_b[31:0] :
             (insn.second_kind == KIND_IMM) ? x2 : 32'd0;

  assign prod = a * b;

  always_comb begin
    case (insn.cmd)
      CMD_ADD: alu_r = a + b;
      CMD_SUB: alu_r = a - b;
      default: alu_r = prod;
    endcase
  end

  always_comb begin
    cond_bad = 1'b0;
    unique case (insn.condition)
      COND_EQ:  cmp_r = $signed(a) == $signed(b);
      COND_GT:  cmp_r = $signed(a) >  $signed(b);
      COND_GTE: cmp_r = $signed(a) >= $signed(b);
      COND_LT:  cmp_r = $signed(a) <  $signed(b);
      COND_LTE: cmp_r = $signed(a) <= $signed(b);
      COND_NE:  cmp_r = $signed(a) != $signed(b);
      default: begin
        cmp_r    = 1'b0;
        cond_bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    trap = TRAP_OK;
    wr   = 1'b0;
    widx = 6'd0;
    wval = 64'd0;
    pv   = 1'b0;
    npc  = pc + 16'd1;
    if (pc >= program_length) begin
      trap = TRAP_PC;
    end else begin
      unique case (insn.cmd)
        CMD_MOV: begin
          if (insn.first_kind != KIND_REG) begin
            trap = TRAP_OPND;
          end else if (!x1_ok) begin
            trap = TRAP_REG;
          end else if (insn.second_kind == KIND_IMM) begin
            wr   = 1'b1;
            widx = x1[5:0];
            wval = {{32{x2[31]}}, x2};
          end else if (insn.second_kind == KIND_REG) begin
            if (!x2_ok) begin
              trap = TRAP_REG;
            end else begin
              wr   = 1'b1;
              widx = x1[5:0];
              wval = reg_b;
            end
          end
        end
        CMD_ADD, CMD_SUB, CMD_MUL: begin
          wval = {{32{alu_r[31]}}, alu_r};
          if (fetch_bad) begin
            trap = TRAP_REG;
          end else if (insn.has_dest) begin
            if (!dst_ok) begin
              trap = TRAP_REG;
            end else begin
              wr   = 1'b1;
              widx = dst[5:0];
            end
          end else if (insn.first_kind == KIND_REG) begin
            wr   = 1'b1;
            widx = x1[5:0];
          end else begin
            trap = TRAP_OPND;
          end
        end
        CMD_CMP: begin
          if (insn.extra_conditions) begin
            trap = TRAP_CCOUNT;
          end else if (fetch_bad) begin
            trap = TRAP_REG;
          end else if (insn.has_dest) begin
            if (!dst_ok) begin
              trap = TRAP_REG;
            end else if (cond_bad) begin
              trap = TRAP_COND;
            end else begin
              wr   = 1'b1;
              widx = dst[5:0];
              wval = {63'd0, cmp_r};
            end
          end
        end
        CMD_JMP: begin
          if (fetch_bad) begin
            trap = TRAP_REG;
          end else if (a == JUMP_WHEN) begin
            if (b[31:16] != 16'd0) begin
              trap = TRAP_PC;
            end else begin
              npc = b[15:0];
            end
          end
        end
        CMD_PRINT: begin
          // register named by first_value whatever its kind
          if (!x1_ok) begin
            trap = TRAP_REG;
          end else begin
            pv = 1'b1;
          end
        end
        CMD_HALT: trap = TRAP_HALT;
        default:  trap = TRAP_INSN;
      endcase
    end
  end

  always_comb begin
    res.trap_code = trap;
    if (trap != TRAP_OK) begin
      res.next_pc       = pc;
      res.reg_written   = 1'b0;
      res.written_index = 6'd0;
      res.written_value = 64'sd0;
      res.print_valid   = 1'b0;
      res.print_value   = 64'sd0;
    end else begin
      res.next_pc       = npc;
      res.reg_written   = wr;
      res.written_index = wr ? widx : 6'd0;
      res.written_value = wr ? $signed(wval) : 64'sd0;
      res.print_valid   = pv;
      res.print_value   = pv ? $signed(reg_a) : 64'sd0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rvx_checker.sv
// port-level checker for register_vm_execute_unit, attached by bind
// depends on register_vm_execute_unit_assert.svh for the assertion macros
`default_nettype none

`include "register_vm_execute_unit_assert.svh"

module rvx_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [159:0] m_tdata
);

  // stalled result holds
  `RVX_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // a trap writes nothing and prints nothing
  `RVX_ASSERT_NOW(a_trap_quiet, m_tvalid && (m_tdata[2:0] != 3'd0), !m_tdata[19] && !m_tdata[90], "trap result carries a write or print")

  // write fields are zero when no register was written
  `RVX_ASSERT_NOW(a_write_zero, m_tvalid && !m_tdata[19], m_tdata[89:20] == 70'd0, "write fields set without a write")

  // after a trap is delivered the block stays silent
  `RVX_ASSERT_NEXT(a_stop_silent, m_tvalid && m_tready && (m_tdata[2:0] != 3'd0), !m_tvalid, "result after a trap")

endmodule

bind register_vm_execute_unit rvx_checker u_rvx_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
